// ----- design/wsd_pkg.sv -----
// Package: shared types, constants and helpers for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int MLEN_W       = 11;
    localparam int LEN_W        = 64;

    localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(BUFFER_BYTES);

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OPCODE    = 2'd1,
        ERR_TOO_LARGE = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_LEN,
        PH_L16,
        PH_L16B,
        PH_L64,
        PH_MASK,
        PH_PAY
    } phase_t;

    typedef struct packed {
        logic [7:0]        payload_byte;
        logic              byte_valid;
        logic              frame_end;
        logic [MLEN_W-1:0] message_length;
        logic              final_flag;
        logic [3:0]        frame_opcode;
        err_t              error_code;
    } result_t;

    function automatic logic [MLEN_W-1:0] to_mlen(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[MLEN_W-1:0];
    endfunction

endpackage

// ----- design/wsd_parser.sv -----
// Frame header parser and payload unmasking, one received byte per transaction.
`timescale 1ns / 1ps

module wsd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic                restart,
    output logic                res_valid,
    output wsd_pkg::result_t    res
);

    wsd_pkg::phase_t              phase_reg, phase_next;
    logic [2:0]                   sub_reg, sub_next;
    logic [wsd_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [wsd_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [1:0]                   idx_reg, idx_next;
    logic                         masked_reg, masked_next;
    logic [7:0]                   key_reg [4];
    logic [7:0]                   key_next [4];
    logic [3:0]                   opcode_reg, opcode_next;
    logic                         fin_reg, fin_next;
    logic [wsd_pkg::CNT_W-1:0]    count_reg, count_next;

    logic                         hdr_done;
    logic [wsd_pkg::CNT_W-1:0]    cnt_inc;
    logic [wsd_pkg::CNT_W-1:0]    cnt_base;
    logic [7:0]                   unmasked;

    always_comb begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        masked_next = masked_reg;
        key_next    = key_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        count_next  = count_reg;
        hdr_done    = 1'b0;
        res_valid   = 1'b0;
        cnt_inc     = count_reg + wsd_pkg::CNT_W'(1);
        cnt_base    = '0;
        unmasked    = rx_byte ^ (masked_reg ? key_reg[idx_reg] : 8'h00);

        res.payload_byte   = '0;
        res.byte_valid     = 1'b0;
        res.frame_end      = 1'b0;
        res.message_length = '0;
        res.final_flag     = fin_reg;
        res.frame_opcode   = opcode_reg;
        res.error_code     = wsd_pkg::ERR_NONE;

        unique case (phase_reg)
            wsd_pkg::PH_LEN: begin
                masked_next = rx_byte[7];
                if (rx_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                    phase_next = wsd_pkg::PH_L16;
                end else if (rx_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                    len_next   = '0;
                    sub_next   = '0;
                    phase_next = wsd_pkg::PH_L64;
                end else begin
                    len_next = wsd_pkg::LEN_W'(rx_byte[6:0]);
                    if (rx_byte[7]) begin
                        sub_next   = '0;
                        phase_next = wsd_pkg::PH_MASK;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            wsd_pkg::PH_L16: begin
                len_next   = {{(wsd_pkg::LEN_W-16){1'b0}}, rx_byte, 8'h00};
                phase_next = wsd_pkg::PH_L16B;
            end
            wsd_pkg::PH_L16B: begin
                len_next = len_reg | wsd_pkg::LEN_W'(rx_byte);
                if (masked_reg) begin
                    sub_next   = '0;
                    phase_next = wsd_pkg::PH_MASK;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            wsd_pkg::PH_L64: begin
                len_next = {len_reg[wsd_pkg::LEN_W-9:0], rx_byte};
                if (sub_reg == 3'd7) begin
                    if (masked_reg) begin
                        sub_next   = '0;
                        phase_next = wsd_pkg::PH_MASK;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end else begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            wsd_pkg::PH_MASK: begin
                key_next[sub_reg[1:0]] = rx_byte;
                if (sub_reg[1:0] == 2'd3) begin
                    hdr_done = 1'b1;
                end else begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            wsd_pkg::PH_PAY: begin
                idx_next         = idx_reg + 2'd1;
                rem_next         = rem_reg - wsd_pkg::LEN_W'(1);
                count_next       = cnt_inc;
                res_valid        = 1'b1;
                res.payload_byte = unmasked;
                res.byte_valid   = 1'b1;
                if (rem_reg == wsd_pkg::LEN_W'(1)) begin
                    res.frame_end      = 1'b1;
                    res.message_length = wsd_pkg::to_mlen(cnt_inc);
                    phase_next         = wsd_pkg::PH_HDR;
                end else if (cnt_inc >= wsd_pkg::BUF_LIMIT) begin
                    res.error_code = wsd_pkg::ERR_TOO_LARGE;
                    count_next     = '0;
                    phase_next     = wsd_pkg::PH_HDR;
                end
            end
            default: begin
                fin_next    = rx_byte[7];
                opcode_next = rx_byte[3:0];
                phase_next  = wsd_pkg::PH_LEN;
            end
        endcase

        if (hdr_done) begin
            idx_next = '0;
            rem_next = len_next;
            if (opcode_reg != wsd_pkg::OP_CONT && opcode_reg != wsd_pkg::OP_BINARY) begin
                res_valid      = 1'b1;
                res.error_code = wsd_pkg::ERR_OPCODE;
                count_next     = '0;
                phase_next     = wsd_pkg::PH_HDR;
            end else begin
                cnt_base   = (opcode_reg == wsd_pkg::OP_BINARY) ? '0 : count_reg;
                count_next = cnt_base;
                if (len_next == '0) begin
                    res_valid          = 1'b1;
                    res.frame_end      = 1'b1;
                    res.message_length = wsd_pkg::to_mlen(cnt_base);
                    phase_next         = wsd_pkg::PH_HDR;
                end else if (cnt_base >= wsd_pkg::BUF_LIMIT) begin
                    res_valid      = 1'b1;
                    res.error_code = wsd_pkg::ERR_TOO_LARGE;
                    count_next     = '0;
                    phase_next     = wsd_pkg::PH_HDR;
                end else begin
                    phase_next = wsd_pkg::PH_PAY;
                end
            end
        end

        if (restart) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && restart)) begin
            phase_reg  <= wsd_pkg::PH_HDR;
            sub_reg    <= '0;
            len_reg    <= '0;
            rem_reg    <= '0;
            idx_reg    <= '0;
            masked_reg <= 1'b0;
            key_reg    <= '{default: 8'h00};
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            count_reg  <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            sub_reg    <= sub_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
            masked_reg <= masked_next;
            key_reg    <= key_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// Top level: WebSocket frame deframer with registered result channel.
`timescale 1ns / 1ps

// One received byte is taken per transaction and a new byte can be accepted in
// every cycle. Each byte is parsed in the cycle it is accepted and its result,
// if any, appears on the m_ channel in the next cycle from a single output
// register; s_ready stays high while that register is empty or being drained,
// so throughput is one byte per cycle whenever the sink keeps m_ready high.
// Header bytes produce no result, except that the last one reports a
// zero-length frame end or an error when there is one. A restart transaction
// returns the parser to the header start and produces no result.
module websocket_frame_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_payload_byte,
    output logic                        m_byte_valid,
    output logic                        m_frame_end,
    output logic [wsd_pkg::MLEN_W-1:0]  m_message_length,
    output logic                        m_final_flag,
    output logic [3:0]                  m_frame_opcode,
    output logic [1:0]                  m_error_code
);

    logic              step;
    logic              res_valid;
    wsd_pkg::result_t  res;
    wsd_pkg::result_t  out_reg;
    logic              out_valid_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (s_rx_byte),
        .restart   (s_restart),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_byte_valid     = out_reg.byte_valid;
    assign m_frame_end      = out_reg.frame_end;
    assign m_message_length = out_reg.message_length;
    assign m_final_flag     = out_reg.final_flag;
    assign m_frame_opcode   = out_reg.frame_opcode;
    assign m_error_code     = out_reg.error_code;

endmodule
